@@ hdl/mask_shadow_cone_dilation_macros.svh @@
// ----------------------------------------------------------------------------
// Mask shadow cone dilation: assertion macros
// Concurrent checks on clk, disabled while arst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef MASK_SHADOW_CONE_DILATION_MACROS_SVH
`define MASK_SHADOW_CONE_DILATION_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MSCD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define MSCD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MSCD_ASSERT_IMP(lbl, ante, cons, msg)
`define MSCD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/mscd_pkg.sv @@
// ----------------------------------------------------------------------------
// Mask shadow cone dilation package
// Sizes, operation codes, bus structs and the cone weight table.
// ----------------------------------------------------------------------------
package mscd_pkg;

	// Image bounds and cone radius.
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int RADIUS     = 8;
	localparam int SPAN       = 2 * RADIUS;
	localparam int FULL_ALPHA = 255;

	// Fixed field widths.
	localparam int ALPHA_W = 8;
	localparam int COORD_W = 8;
	localparam int CFG_W   = 9;

	// Derived widths.
	localparam int XW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WDW     = $clog2(MAX_WIDTH + 1);
	localparam int HDW     = $clog2(MAX_HEIGHT + 1);
	localparam int SJW     = $clog2(SPAN);
	localparam int SYW     = ((YW > SJW) ? YW : SJW) + 2;
	localparam int SH_AW   = XW + YW;
	localparam int SH_DEPTH = 2 ** SH_AW;
	localparam int EXT_W   = MAX_WIDTH + 2 * SPAN;
	localparam int EIW     = $clog2(EXT_W);

	// Operation codes.
	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_COMPUTE = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	// Source row read request from the compute pipeline.
	typedef struct packed {
		logic          re;
		logic [YW-1:0] addr;
	} src_rd_t;

	// Shadow pixel write from the compute pipeline.
	typedef struct packed {
		logic               we;
		logic [SH_AW-1:0]   addr;
		logic [ALPHA_W-1:0] data;
	} sh_wr_t;

	// Cone weights indexed [dy + RADIUS][dx + RADIUS].
	typedef logic [SPAN-1:0][SPAN-1:0][ALPHA_W-1:0] cone_tab_t;

	// The weight is FULL_ALPHA - k with k the smallest integer such that
	// RADIUS^2 * k^2 >= FULL_ALPHA^2 * d^2; zero at or beyond the radius.
	function automatic cone_tab_t build_cone();
		cone_tab_t tab;
		longint    d2;
		longint    rr;
		longint    lhs;
		longint    kk;
		longint    dx;
		longint    dy;
		tab = '0;
		rr  = longint'(RADIUS) * longint'(RADIUS);
		for (int j = 0; j < SPAN; j++) begin
			for (int i = 0; i < SPAN; i++) begin
				dy  = longint'(j - RADIUS);
				dx  = longint'(i - RADIUS);
				d2  = dx * dx + dy * dy;
				lhs = longint'(FULL_ALPHA) * longint'(FULL_ALPHA) * d2;
				kk  = 0;
				for (int k = 0; k < FULL_ALPHA; k++) begin
					if (rr * longint'(k) * longint'(k) < lhs) begin
						kk = kk + 1;
					end
				end
				if (d2 >= rr) begin
					tab[j][i] = '0;
				end else begin
					tab[j][i] = ALPHA_W'(longint'(FULL_ALPHA) - kk);
				end
			end
		end
		return tab;
	endfunction

	localparam cone_tab_t CONE = build_cone();

endpackage

@@ hdl/mscd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mscd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/mscd_cone_pipe.sv @@
// ----------------------------------------------------------------------------
// Cone dilation pipeline
// Sweeps the image, reads one source row per window row and folds the
// weighted maximum into each shadow pixel.
// ----------------------------------------------------------------------------
`include "mask_shadow_cone_dilation_macros.svh"

module mscd_cone_pipe (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [mscd_pkg::WDW-1:0]  img_w,
	input  logic [mscd_pkg::HDW-1:0]  img_h,
	output mscd_pkg::src_rd_t         src_rd,
	input  logic [mscd_pkg::MAX_WIDTH-1:0] src_rdata,
	output mscd_pkg::sh_wr_t          sh_wr,
	output logic                      done
);

	import mscd_pkg::*;

	// Sweep counters.
	logic            run_q;
	logic            draining_q;
	logic [XW-1:0]   tx_q;
	logic [YW-1:0]   ty_q;
	logic [SJW-1:0]  j_q;
	logic            last_j;
	logic            last_x;
	logic            last_y;
	logic signed [SYW-1:0] sy;
	logic            row_ok;

	// Stage registers.
	logic              v_s1, v_s2, v_s3;
	logic              first_s1, first_s2, first_s3;
	logic              last_s1, last_s2, last_s3;
	logic              row_ok_s1;
	logic [SJW-1:0]    j_s1, j_s2;
	logic [XW-1:0]     tx_s1, tx_s2, tx_s3;
	logic [YW-1:0]     ty_s1, ty_s2, ty_s3;
	logic [SPAN-1:0]   window_s2;
	logic [ALPHA_W-1:0] rowmax_s3;
	logic [ALPHA_W-1:0] acc_q;

	// Stage logic.
	logic [EXT_W-1:0]   ext_row;
	logic [EIW-1:0]     base;
	logic [SPAN-1:0]    slice;
	logic [SPAN-1:0]    window;
	logic [ALPHA_W-1:0] node [1:2*SPAN-1];
	logic [ALPHA_W-1:0] acc_next;

	// Window row and the source row it reads.
	assign last_j = (j_q == SJW'(SPAN - 1));
	assign last_x = ((32'(tx_q) + 32'd1) == 32'(img_w));
	assign last_y = ((32'(ty_q) + 32'd1) == 32'(img_h));
	assign sy     = signed'(SYW'(ty_q)) + signed'(SYW'(RADIUS)) - signed'(SYW'(j_q));
	assign row_ok = !sy[SYW-1] && (sy < signed'(SYW'(img_h)));

	assign src_rd.re   = run_q && row_ok;
	assign src_rd.addr = sy[YW-1:0];

	// Sweep over rows, columns and window rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			draining_q <= 1'b0;
			tx_q       <= '0;
			ty_q       <= '0;
			j_q        <= '0;
		end else begin
			if (start) begin
				run_q      <= 1'b1;
				draining_q <= 1'b1;
				tx_q       <= '0;
				ty_q       <= '0;
				j_q        <= '0;
			end else if (run_q) begin
				if (!last_j) begin
					j_q <= j_q + 1'b1;
				end else begin
					j_q <= '0;
					if (!last_x) begin
						tx_q <= tx_q + 1'b1;
					end else begin
						tx_q <= '0;
						if (!last_y) begin
							ty_q <= ty_q + 1'b1;
						end else begin
							run_q <= 1'b0;
						end
					end
				end
			end
			if (done) begin
				draining_q <= 1'b0;
			end
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= run_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		first_s1  <= (j_q == '0);
		last_s1   <= last_j;
		row_ok_s1 <= row_ok;
		j_s1      <= j_q;
		tx_s1     <= tx_q;
		ty_s1     <= ty_q;

		first_s2  <= first_s1;
		last_s2   <= last_s1;
		j_s2      <= j_s1;
		tx_s2     <= tx_s1;
		ty_s2     <= ty_s1;
		window_s2 <= window;

		first_s3  <= first_s2;
		last_s3   <= last_s2;
		tx_s3     <= tx_s2;
		ty_s3     <= ty_s2;
		rowmax_s3 <= node[1];
	end

	// Stage 1: cut the window columns out of the source row, masked to the image.
	assign ext_row = {{SPAN{1'b0}}, src_rdata, {SPAN{1'b0}}};
	assign base    = EIW'(tx_s1) + EIW'(RADIUS + 1);
	assign slice   = ext_row[base +: SPAN];

	always_comb begin
		for (int m = 0; m < SPAN; m++) begin
			window[m] = slice[m] && row_ok_s1 &&
				((32'(tx_s1) + 32'(m) + 32'd1) < (32'(img_w) + 32'(RADIUS)));
		end
	end

	// Stage 2: weigh each present source and take the maximum through a tree.
	always_comb begin
		for (int m = 0; m < SPAN; m++) begin
			node[SPAN + m] = window_s2[m] ? CONE[j_s2][SPAN - 1 - m] : '0;
		end
		for (int n = SPAN - 1; n >= 1; n--) begin
			node[n] = (node[2 * n] > node[2 * n + 1]) ? node[2 * n] : node[2 * n + 1];
		end
	end

	// Stage 3: fold the row maximum into the pixel and write it on the last row.
	assign acc_next = first_s3 ? rowmax_s3 : ((rowmax_s3 > acc_q) ? rowmax_s3 : acc_q);

	always_ff @(posedge clk) begin
		if (v_s3) begin
			acc_q <= acc_next;
		end
	end

	assign sh_wr.we   = v_s3 && last_s3;
	assign sh_wr.addr = {ty_s3, tx_s3};
	assign sh_wr.data = acc_next;

	// The sweep is finished once the last pixel has left the pipeline.
	assign done = draining_q && !run_q && !v_s1 && !v_s2 && !v_s3;

	`MSCD_ASSERT_IMP(a_wr_in_image, sh_wr.we, (32'(tx_s3) < 32'(img_w)) && (32'(ty_s3) < 32'(img_h)), "shadow write outside the image")
	`MSCD_ASSERT_IMP(a_no_restart, start, !draining_q, "compute started while a sweep runs")
	`MSCD_ASSERT_NXT(a_start_runs, start, run_q, "sweep did not begin after start")

endmodule

@@ hdl/mask_shadow_cone_dilation.sv @@
// ----------------------------------------------------------------------------
// Mask shadow cone dilation
// Loads a binary mask, builds a cone-falloff shadow of it and reads it back.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; a result is shown for
// exactly one cycle with valid high and cannot be held off. A write beat
// inside the image reads and writes back one source row word. A read beat
// reads the shadow store, and its result is registered in the READ state. A
// compute beat sweeps the image at one source row read per window row per
// pixel through the single read port of the source row memory; its result
// follows the last shadow write. The memories are not cleared after reset.
`include "mask_shadow_cone_dilation_macros.svh"

module mask_shadow_cone_dilation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    operation,
	input  logic [mscd_pkg::COORD_W-1:0]  x_coord,
	input  logic [mscd_pkg::COORD_W-1:0]  y_coord,
	input  logic [mscd_pkg::ALPHA_W-1:0]  source_alpha,
	output logic                          valid,
	output logic [mscd_pkg::ALPHA_W-1:0]  shadow_alpha,
	output logic                          compute_done,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [mscd_pkg::CFG_W-1:0]    cfg_data
);

	import mscd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_WRITE   = 4'b0010,
		ST_READ    = 4'b0100,
		ST_COMPUTE = 4'b1000
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    width_q;
	logic [CFG_W-1:0]    height_q;
	logic [WDW-1:0]      img_w;
	logic [HDW-1:0]      img_h;
	logic                accept;
	logic                in_image;

	// Pending write and read.
	logic [XW-1:0]       wx_q;
	logic [YW-1:0]       wy_q;
	logic                wnz_q;
	logic                rd_inside_q;

	// Result registers.
	logic                valid_q;
	logic [ALPHA_W-1:0]  alpha_q;
	logic                cdone_q;

	// Memory ports.
	logic                src_re;
	logic [YW-1:0]       src_raddr;
	logic [MAX_WIDTH-1:0] src_rdata;
	logic [MAX_WIDTH-1:0] row_new;
	logic                sh_re;
	logic [ALPHA_W-1:0]  sh_rdata;

	// Compute pipeline.
	logic                pipe_start;
	logic                pipe_done;
	src_rd_t             pipe_src;
	sh_wr_t              pipe_sh;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(256);
			height_q <= CFG_W'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Image size, saturated to the supported range.
	always_comb begin
		if (width_q == '0) begin
			img_w = WDW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			img_w = WDW'(MAX_WIDTH);
		end else begin
			img_w = WDW'(width_q);
		end
		if (height_q == '0) begin
			img_h = HDW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			img_h = HDW'(MAX_HEIGHT);
		end else begin
			img_h = HDW'(height_q);
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign in_image = (32'(x_coord) < 32'(img_w)) && (32'(y_coord) < 32'(img_h));

	// Source map: one row of presence bits per word, read-modify-write on load.
	assign src_re    = (accept && (operation == OP_WRITE) && in_image) || pipe_src.re;
	assign src_raddr = (state_q == ST_COMPUTE) ? pipe_src.addr : YW'(y_coord);

	always_comb begin
		row_new       = src_rdata;
		row_new[wx_q] = wnz_q;
	end

	mscd_ram #(
		.WIDTH (MAX_WIDTH),
		.DEPTH (MAX_HEIGHT)
	) u_src_ram (
		.clk   (clk),
		.we    (state_q == ST_WRITE),
		.waddr (wy_q),
		.wdata (row_new),
		.re    (src_re),
		.raddr (src_raddr),
		.rdata (src_rdata)
	);

	// Shadow store: written by the sweep, read by read beats.
	assign sh_re = accept && (operation == OP_READ);

	mscd_ram #(
		.WIDTH (ALPHA_W),
		.DEPTH (SH_DEPTH)
	) u_sh_ram (
		.clk   (clk),
		.we    (pipe_sh.we),
		.waddr (pipe_sh.addr),
		.wdata (pipe_sh.data),
		.re    (sh_re),
		.raddr ({YW'(y_coord), XW'(x_coord)}),
		.rdata (sh_rdata)
	);

	assign pipe_start = accept && (operation == OP_COMPUTE);

	mscd_cone_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (pipe_start),
		.img_w     (img_w),
		.img_h     (img_h),
		.src_rd    (pipe_src),
		.src_rdata (src_rdata),
		.sh_wr     (pipe_sh),
		.done      (pipe_done)
	);

	// Pending write and read details.
	always_ff @(posedge clk) begin
		if (accept) begin
			wx_q        <= XW'(x_coord);
			wy_q        <= YW'(y_coord);
			wnz_q       <= (source_alpha != '0);
			rd_inside_q <= in_image;
		end
	end

	// Control sequence and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			cdone_q <= 1'b0;
		end else begin
			valid_q <= (state_q == ST_READ) || ((state_q == ST_COMPUTE) && pipe_done);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (operation)
							OP_WRITE: begin
								if (in_image) begin
									state_q <= ST_WRITE;
								end
							end
							OP_COMPUTE: state_q <= ST_COMPUTE;
							OP_READ:    state_q <= ST_READ;
							default: ;
						endcase
					end
				end
				ST_WRITE: state_q <= ST_IDLE;
				ST_READ: begin
					cdone_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				ST_COMPUTE: begin
					if (pipe_done) begin
						cdone_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result value.
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			alpha_q <= rd_inside_q ? sh_rdata : '0;
		end else if (state_q == ST_COMPUTE) begin
			alpha_q <= '0;
		end
	end

	assign valid        = valid_q;
	assign shadow_alpha = alpha_q;
	assign compute_done = cdone_q;

	`MSCD_ASSERT_IMP(a_src_rd_compute, pipe_src.re, state_q == ST_COMPUTE, "sweep read outside compute")
	`MSCD_ASSERT_IMP(a_sh_wr_compute, pipe_sh.we, state_q == ST_COMPUTE, "shadow write outside compute")
	`MSCD_ASSERT_IMP(a_result_cause, valid_q, $past(state_q == ST_READ) || $past(pipe_done), "result without a read or a finished sweep")

endmodule

@@ verif/mask_shadow_cone_dilation_test.sv @@
// ----------------------------------------------------------------------------
// Mask shadow cone dilation testbench
// Loads binary masks into windows of many sizes, builds shadows and reads them
// back. A directed table comes first, then random load, build and read phases.
// Result beats are checked against the predictor, or the table on typed rows.
// ----------------------------------------------------------------------------
module mask_shadow_cone_dilation_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mscd_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int PIXELS      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ITEM_TARGET = 1550;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [ALPHA_W-1:0] shadow;
		logic               done;
	} shade_result_t;

	typedef enum logic {
		ROW_BEAT,
		ROW_REG
	} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		reg_idx_t           reg_sel;
		logic [CFG_W-1:0]   value;
		logic [1:0]         op;
		logic [COORD_W-1:0] xc;
		logic [COORD_W-1:0] yc;
		logic [ALPHA_W-1:0] alpha;
		logic               typed;
		shade_result_t      want;
	} script_row_t;

	localparam shade_result_t SHADE_ZERO = '{8'd0, 1'b0};
	localparam shade_result_t SHADE_FULL = '{8'd255, 1'b0};
	localparam shade_result_t SHADE_DONE = '{8'd0, 1'b1};

	// Directed part: a 1x1 window reached through zero register values, then a
	// 3x3 window with one set pixel in the middle.
	localparam script_row_t SCRIPT [28] = '{
		'{ROW_REG,  REG_WIDTH,  9'd0, OP_WRITE,   8'd0,   8'd0,   8'd0,   1'b0, SHADE_ZERO},
		'{ROW_REG,  REG_HEIGHT, 9'd0, OP_WRITE,   8'd0,   8'd0,   8'd0,   1'b0, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_READ,    8'd255, 8'd255, 8'd0,   1'b1, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_NONE,    8'd255, 8'd255, 8'd255, 1'b0, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_WRITE,   8'd0,   8'd0,   8'd255, 1'b0, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_WRITE,   8'd255, 8'd255, 8'd255, 1'b0, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_COMPUTE, 8'd0,   8'd0,   8'd0,   1'b1, SHADE_DONE},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_READ,    8'd0,   8'd0,   8'd0,   1'b1, SHADE_FULL},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_READ,    8'd0,   8'd255, 8'd128, 1'b1, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_WRITE,   8'd0,   8'd0,   8'd0,   1'b0, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_COMPUTE, 8'd0,   8'd0,   8'd0,   1'b1, SHADE_DONE},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_READ,    8'd0,   8'd0,   8'd0,   1'b0, SHADE_ZERO},
		'{ROW_REG,  REG_WIDTH,  9'd3, OP_WRITE,   8'd0,   8'd0,   8'd0,   1'b0, SHADE_ZERO},
		'{ROW_REG,  REG_HEIGHT, 9'd3, OP_WRITE,   8'd0,   8'd0,   8'd0,   1'b0, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_WRITE,   8'd1,   8'd0,   8'd0,   1'b0, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_WRITE,   8'd2,   8'd0,   8'd0,   1'b0, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_WRITE,   8'd0,   8'd1,   8'd0,   1'b0, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_WRITE,   8'd1,   8'd1,   8'd1,   1'b0, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_WRITE,   8'd2,   8'd1,   8'd0,   1'b0, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_WRITE,   8'd0,   8'd2,   8'd0,   1'b0, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_WRITE,   8'd1,   8'd2,   8'd0,   1'b0, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_WRITE,   8'd2,   8'd2,   8'd0,   1'b0, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_COMPUTE, 8'd0,   8'd0,   8'd0,   1'b1, SHADE_DONE},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_READ,    8'd1,   8'd1,   8'd0,   1'b1, SHADE_FULL},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_READ,    8'd0,   8'd0,   8'd0,   1'b0, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_READ,    8'd2,   8'd1,   8'd0,   1'b0, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_READ,    8'd2,   8'd2,   8'd0,   1'b0, SHADE_ZERO},
		'{ROW_BEAT, REG_WIDTH,  9'd0, OP_READ,    8'd3,   8'd0,   8'd0,   1'b1, SHADE_ZERO}
	};

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               start        = 1'b0;
	logic               busy;
	logic [1:0]         operation    = OP_WRITE;
	logic [COORD_W-1:0] x_coord      = '0;
	logic [COORD_W-1:0] y_coord      = '0;
	logic [ALPHA_W-1:0] source_alpha = '0;
	logic               valid;
	logic [ALPHA_W-1:0] shadow_alpha;
	logic               compute_done;
	logic               cfg_we       = 1'b0;
	logic [0:0]         cfg_index    = '0;
	logic [CFG_W-1:0]   cfg_data     = '0;

	// Predictor state: mask bits, built shadow, registers and cone weights.
	bit                 mask_bit [PIXELS];
	bit [ALPHA_W-1:0]   shadow_map [PIXELS];
	logic [CFG_W-1:0]   width_reg  = 9'd256;
	logic [CFG_W-1:0]   height_reg = 9'd256;
	logic [ALPHA_W-1:0] falloff [SPAN][SPAN];

	// Expected result beats, oldest first.
	shade_result_t      awaiting [$];

	// Stimulus side bookkeeping: which pixels hold a mask bit or a built shadow.
	bit                 loaded [PIXELS];
	bit                 shaded [PIXELS];
	int                 plan_w = MAX_WIDTH;
	int                 plan_h = MAX_HEIGHT;
	int                 useful_beats = 0;
	int                 calm_left = 0;
	int                 errors = 0;
	int                 stall_cycles = 0;
	logic               typed_on = 1'b0;
	shade_result_t      typed_val = '0;

	mask_shadow_cone_dilation dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.source_alpha (source_alpha),
		.valid        (valid),
		.shadow_alpha (shadow_alpha),
		.compute_done (compute_done),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// A register value used as a size is saturated into [1, top].
	function automatic int eff_dim(input logic [CFG_W-1:0] v, input int top);
		if (v == 0) return 1;
		if (int'(v) > top) return top;
		return int'(v);
	endfunction

	// Cone weight is 255 - k for the smallest k with R^2 k^2 >= 255^2 d^2.
	function automatic logic [ALPHA_W-1:0] falloff_weight(input int dx, input int dy);
		int d2;
		int k;
		d2 = dx * dx + dy * dy;
		k  = 0;
		if (d2 >= RADIUS * RADIUS) return '0;
		while (k < FULL_ALPHA && RADIUS * RADIUS * k * k < FULL_ALPHA * FULL_ALPHA * d2)
			k++;
		return ALPHA_W'(FULL_ALPHA - k);
	endfunction

	// Rebuild the shadow of the current window from the mask bits.
	function automatic void sweep_shadow();
		int                 w;
		int                 h;
		int                 sx;
		int                 sy;
		logic [ALPHA_W-1:0] best;
		w = eff_dim(width_reg, MAX_WIDTH);
		h = eff_dim(height_reg, MAX_HEIGHT);
		for (int ty = 0; ty < h; ty++) begin
			for (int tx = 0; tx < w; tx++) begin
				best = '0;
				if (mask_bit[ty * MAX_WIDTH + tx]) begin
					best = ALPHA_W'(FULL_ALPHA);
				end else begin
					for (int dy = -RADIUS; dy < RADIUS; dy++) begin
						sy = ty - dy;
						if (sy < 0 || sy >= h) continue;
						for (int dx = -RADIUS; dx < RADIUS; dx++) begin
							sx = tx - dx;
							if (sx < 0 || sx >= w) continue;
							if (mask_bit[sy * MAX_WIDTH + sx]
									&& falloff[dy + RADIUS][dx + RADIUS] > best) begin
								best = falloff[dy + RADIUS][dx + RADIUS];
							end
						end
					end
				end
				shadow_map[ty * MAX_WIDTH + tx] = best;
			end
		end
	endfunction

	// Apply one accepted beat to the predictor; returns 1 when it yields a result.
	function automatic bit shade_beat(input logic [1:0] op, input logic [COORD_W-1:0] xc,
			input logic [COORD_W-1:0] yc, input logic [ALPHA_W-1:0] al,
			output shade_result_t res);
		bit in_img;
		int idx;
		in_img = (int'(xc) < eff_dim(width_reg, MAX_WIDTH))
			&& (int'(yc) < eff_dim(height_reg, MAX_HEIGHT));
		idx    = int'(yc) * MAX_WIDTH + int'(xc);
		res    = '0;
		case (op)
			OP_WRITE: begin
				if (in_img) mask_bit[idx] = (al != 0);
				return 1'b0;
			end
			OP_COMPUTE: begin
				sweep_shadow();
				res.done = 1'b1;
				return 1'b1;
			end
			OP_READ: begin
				res.shadow = in_img ? shadow_map[idx] : '0;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Check result beats, track register writes and predict accepted beats.
	always @(posedge clk) begin : check_and_predict
		shade_result_t got;
		shade_result_t want;
		shade_result_t calc;
		if (arst_n) begin
			if (valid) begin
				got.shadow = shadow_alpha;
				got.done   = compute_done;
				if (awaiting.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got shadow_alpha %0d compute_done %0d",
						$time, got.shadow, got.done);
				end else begin
					want = awaiting.pop_front();
					if (got.shadow !== want.shadow) begin
						errors++;
						$display("%0t: shadow_alpha expected %0d, got %0d",
							$time, want.shadow, got.shadow);
					end
					if (got.done !== want.done) begin
						errors++;
						$display("%0t: compute_done expected %0d, got %0d",
							$time, want.done, got.done);
					end
				end
			end
			if (cfg_we) begin
				if (reg_idx_t'(cfg_index) == REG_WIDTH) width_reg = cfg_data;
				else height_reg = cfg_data;
			end
			if (start && !busy) begin
				if (shade_beat(operation, x_coord, y_coord, source_alpha, calc))
					awaiting.push_back(typed_on ? typed_val : calc);
			end
		end
	end

	// End the run when nothing moves for far longer than the slowest shadow build.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || valid) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("mask_shadow_cone_dilation: mismatch");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Idle cycles before a beat, with calm stretches of none.
	function automatic int pick_gap();
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 60);
		return $urandom_range(0, 18);
	endfunction

	// Present one beat from the falling edge and hold it until it is taken.
	task automatic send_item(input logic [1:0] op, input logic [COORD_W-1:0] xc,
			input logic [COORD_W-1:0] yc, input logic [ALPHA_W-1:0] al,
			input logic typed, input shade_result_t want);
		int gap;
		bit in_img;
		gap = pick_gap();
		in_img = (int'(xc) < plan_w) && (int'(yc) < plan_h);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start        <= 1'b1;
		operation    <= op;
		x_coord      <= xc;
		y_coord      <= yc;
		source_alpha <= al;
		typed_on  = typed;
		typed_val = want;
		do @(posedge clk); while (busy);
		if (op == OP_WRITE && in_img) loaded[int'(yc) * MAX_WIDTH + int'(xc)] = 1'b1;
		if (op == OP_COMPUTE) begin
			for (int ty = 0; ty < plan_h; ty++)
				for (int tx = 0; tx < plan_w; tx++)
					shaded[ty * MAX_WIDTH + tx] = 1'b1;
		end
		if (op != OP_NONE && !(op == OP_WRITE && !in_img)) useful_beats++;
	endtask

	// Registers change only once the block has gone quiet.
	task automatic write_register(input reg_idx_t sel, input logic [CFG_W-1:0] val);
		@(negedge clk);
		start <= 1'b0;
		while (awaiting.size() != 0) @(negedge clk);
		// A write beat can still be in flight.
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (sel == REG_WIDTH) plan_w = eff_dim(val, MAX_WIDTH);
		else plan_h = eff_dim(val, MAX_HEIGHT);
	endtask

	// A coordinate outside the window; the window is never the full image here.
	task automatic pick_outside(output logic [COORD_W-1:0] px, output logic [COORD_W-1:0] py);
		if (plan_h >= MAX_HEIGHT || (plan_w < MAX_WIDTH && $urandom_range(0, 1) == 1)) begin
			px = $urandom_range(plan_w, MAX_WIDTH - 1);
			py = $urandom_range(0, 255);
		end else begin
			px = $urandom_range(0, 255);
			py = $urandom_range(plan_h, MAX_HEIGHT - 1);
		end
	endtask

	// Read a built pixel inside the window, or any pixel outside it.
	task automatic send_read();
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		px = $urandom_range(0, plan_w - 1);
		py = $urandom_range(0, plan_h - 1);
		if ($urandom_range(0, 3) == 0 || !shaded[int'(py) * MAX_WIDTH + int'(px)])
			pick_outside(px, py);
		send_item(OP_READ, px, py, $urandom_range(0, 255), 1'b0, '0);
	endtask

	// Stray beats: unused operation, writes outside the window, reads.
	task automatic send_noise();
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		case ($urandom_range(0, 2))
			0: send_item(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), 1'b0, '0);
			1: begin
				pick_outside(px, py);
				send_item(OP_WRITE, px, py, $urandom_range(0, 255), 1'b0, '0);
			end
			default: send_read();
		endcase
	endtask

	function automatic bit window_loaded();
		for (int ty = 0; ty < plan_h; ty++)
			for (int tx = 0; tx < plan_w; tx++)
				if (!loaded[ty * MAX_WIDTH + tx]) return 1'b0;
		return 1'b1;
	endfunction

	// One phase: set the window, load all or part of the mask, build, read back.
	task automatic run_phase(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
		int order [$];
		int plan;
		int density;
		int j;
		int t;
		int idx;
		write_register(REG_WIDTH, w_raw);
		write_register(REG_HEIGHT, h_raw);
		// 0 loads the whole window, 1 rewrites part of it, 2 keeps what is stored.
		plan    = window_loaded() ? $urandom_range(0, 2) : 0;
		density = $urandom_range(2, 50);
		for (int ty = 0; ty < plan_h; ty++)
			for (int tx = 0; tx < plan_w; tx++)
				if (plan == 0 || (plan == 1 && $urandom_range(0, 3) == 0))
					order.push_back(ty * MAX_WIDTH + tx);
		for (int i = order.size() - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			t        = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		foreach (order[i]) begin
			if ($urandom_range(0, 7) == 0) send_noise();
			idx = order[i];
			send_item(OP_WRITE, idx % MAX_WIDTH, idx / MAX_WIDTH,
				($urandom_range(0, 99) < density) ? $urandom_range(1, 255) : 0, 1'b0, '0);
		end
		send_item(OP_COMPUTE, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), 1'b0, '0);
		repeat ($urandom_range(4, 30)) send_read();
	endtask

	initial begin : stimulus
		int w_next;
		int h_next;
		for (int j = 0; j < SPAN; j++)
			for (int i = 0; i < SPAN; i++)
				falloff[j][i] = falloff_weight(i - RADIUS, j - RADIUS);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table.
		for (int i = 0; i < $size(SCRIPT); i++) begin
			if (SCRIPT[i].kind == ROW_REG)
				write_register(SCRIPT[i].reg_sel, SCRIPT[i].value);
			else
				send_item(SCRIPT[i].op, SCRIPT[i].xc, SCRIPT[i].yc, SCRIPT[i].alpha,
					SCRIPT[i].typed, SCRIPT[i].want);
		end

		// Widest and tallest windows, reached through saturating values too.
		run_phase(9'd256, 9'd1);
		run_phase(9'd0, 9'd511);

		// Random phases, mostly small windows so that each build stays short.
		while (useful_beats < ITEM_TARGET) begin
			case ($urandom_range(0, 5))
				0: begin
					w_next = 0;
					h_next = $urandom_range(1, 24);
				end
				1: begin
					w_next = $urandom_range(1, 24);
					h_next = 0;
				end
				2: begin
					// Shrink the window over pixels that are already stored.
					w_next = $urandom_range(1, (plan_w < 16) ? plan_w : 16);
					h_next = $urandom_range(1, (plan_h < 16) ? plan_h : 16);
				end
				default: begin
					w_next = $urandom_range(1, 16);
					h_next = $urandom_range(1, 16);
				end
			endcase
			run_phase(CFG_W'(w_next), CFG_W'(h_next));
		end

		@(negedge clk);
		start <= 1'b0;
		while (awaiting.size() != 0) @(negedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("mask_shadow_cone_dilation: match");
		else
			$display("mask_shadow_cone_dilation: mismatch");
		$finish;
	end

endmodule
